[rtl/core/trit_pkg.sv]
// Package for the triangle and rectangle intersection test unit.
// Holds the widths, payload structs and result codes; depends on nothing.
package trit_pkg;
    localparam int COORD_BITS = 20;
    localparam int SIZE_BITS = COORD_BITS - 1;
    localparam int EXT_BITS = COORD_BITS + 1;
    localparam int DIFF_BITS = COORD_BITS + 2;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int LIMIT_BITS = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [0:0] REG_PARALLEL_LIMIT = 1'b0;
    localparam logic [0:0] REG_ON_EDGE_LIMIT = 1'b1;
    localparam logic [LIMIT_BITS-1:0] PARALLEL_LIMIT_RESET = 32'd7;
    localparam logic [LIMIT_BITS-1:0] ON_EDGE_LIMIT_RESET = 32'd656;

    typedef enum logic [1:0] {
        CAUSE_APART = 2'd0,
        CAUSE_CORNER = 2'd1,
        CAUSE_CROSS = 2'd2,
        CAUSE_NONE = 2'd3
    } cause_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] tri_x0;
        logic signed [COORD_BITS-1:0] tri_y0;
        logic signed [COORD_BITS-1:0] tri_x1;
        logic signed [COORD_BITS-1:0] tri_y1;
        logic signed [COORD_BITS-1:0] tri_x2;
        logic signed [COORD_BITS-1:0] tri_y2;
        logic signed [COORD_BITS-1:0] box_left;
        logic signed [COORD_BITS-1:0] box_top;
        logic [SIZE_BITS-1:0] box_width;
        logic [SIZE_BITS-1:0] box_height;
    } pair_t;

    typedef struct packed {
        logic hit;
        logic [1:0] cause;
    } result_t;

    typedef struct packed {
        logic apart;
        logic signed [2:0][COORD_BITS-1:0] vx;
        logic signed [2:0][COORD_BITS-1:0] vy;
        logic signed [EXT_BITS-1:0] left;
        logic signed [EXT_BITS-1:0] right;
        logic signed [EXT_BITS-1:0] top;
        logic signed [EXT_BITS-1:0] bottom;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;
endpackage

[rtl/core/trit_front.sv]
// Front end: registers an accepted pair, works out the rectangle's right and bottom edges and runs the box test.
// Depends on trit_pkg.
module trit_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  trit_pkg::pair_t pair,
    output logic            push,
    output trit_pkg::job_t  job
);
    logic push_reg;
    trit_pkg::job_t job_reg;
    trit_pkg::job_t job_next;
    logic signed [trit_pkg::COORD_BITS-1:0] minx, maxx, miny, maxy;

    always_comb
    begin
        minx = pair.tri_x0;
        maxx = pair.tri_x0;
        miny = pair.tri_y0;
        maxy = pair.tri_y0;
        if (pair.tri_x1 < minx) minx = pair.tri_x1;
        if (pair.tri_x2 < minx) minx = pair.tri_x2;
        if (pair.tri_x1 > maxx) maxx = pair.tri_x1;
        if (pair.tri_x2 > maxx) maxx = pair.tri_x2;
        if (pair.tri_y1 < miny) miny = pair.tri_y1;
        if (pair.tri_y2 < miny) miny = pair.tri_y2;
        if (pair.tri_y1 > maxy) maxy = pair.tri_y1;
        if (pair.tri_y2 > maxy) maxy = pair.tri_y2;
        job_next.vx[0] = pair.tri_x0;
        job_next.vx[1] = pair.tri_x1;
        job_next.vx[2] = pair.tri_x2;
        job_next.vy[0] = pair.tri_y0;
        job_next.vy[1] = pair.tri_y1;
        job_next.vy[2] = pair.tri_y2;
        job_next.left = trit_pkg::EXT_BITS'(pair.box_left);
        job_next.top = trit_pkg::EXT_BITS'(pair.box_top);
        job_next.right = job_next.left
            + $signed({2'b00, pair.box_width});
        job_next.bottom = job_next.top
            + $signed({2'b00, pair.box_height});
        job_next.apart = (job_next.right <= trit_pkg::EXT_BITS'(minx))
            || (maxx <= pair.box_left)
            || (job_next.bottom <= trit_pkg::EXT_BITS'(miny))
            || (maxy <= pair.box_top);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_reg <= 1'b0;
        end
        else
        begin
            push_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job_next;
        end
    end

    assign push = push_reg;
    assign job = job_reg;
endmodule

[rtl/core/trit_queue.sv]
// Short queue of classified jobs between the front end and the back end.
// Depends on trit_pkg.
module trit_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  trit_pkg::job_t         din,
    input  logic                   pop,
    output trit_pkg::job_t         dout,
    output trit_pkg::queue_stat_t  stat
);
    trit_pkg::job_t slot_reg [trit_pkg::QUEUE_DEPTH];
    logic [trit_pkg::QPTR_BITS-1:0] wr_reg, rd_reg;
    logic [trit_pkg::QPTR_BITS:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            count_reg <= count_reg + (trit_pkg::QPTR_BITS + 1)'(push)
                - (trit_pkg::QPTR_BITS + 1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= din;
        end
    end

    assign dout = slot_reg[rd_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full = (count_reg == (trit_pkg::QPTR_BITS + 1)'(trit_pkg::QUEUE_DEPTH));
endmodule

[rtl/core/trit_back.sv]
// Back end: cross products, corner and edge crossing decisions, and the result register.
// Depends on trit_pkg.
module trit_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop,
    input  trit_pkg::job_t                    job,
    input  logic [trit_pkg::LIMIT_BITS-1:0]   parallel_limit,
    input  logic [trit_pkg::LIMIT_BITS-1:0]   on_edge_limit,
    output logic                              done,
    output trit_pkg::result_t                 result
);
    localparam int DW = trit_pkg::DIFF_BITS;
    localparam int PW = trit_pkg::PROD_BITS;
    localparam int XW = trit_pkg::CROSS_BITS;

    logic signed [DW-1:0] ex [3];
    logic signed [DW-1:0] ey [3];
    logic signed [DW-1:0] cxs [4];
    logic signed [DW-1:0] cys [4];
    logic signed [DW-1:0] bx [4];
    logic signed [DW-1:0] by [4];
    logic signed [DW-1:0] px [4][3];
    logic signed [DW-1:0] py [4][3];

    logic signed [PW-1:0] pc1_reg [4][3];
    logic signed [PW-1:0] pc2_reg [4][3];
    logic signed [PW-1:0] pd1_reg [4][3];
    logic signed [PW-1:0] pd2_reg [4][3];
    logic signed [PW-1:0] pt1_reg [4][3];
    logic signed [PW-1:0] pt2_reg [4][3];
    logic signed [XW-1:0] cc_reg [4][3];
    logic signed [XW-1:0] dd_reg [4][3];
    logic signed [XW-1:0] tt_reg [4][3];

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, done_reg;
    logic s1_apart_reg, s2_apart_reg, s3_apart_reg;
    logic [3:0] inside_reg;
    logic [11:0] cross_reg;
    trit_pkg::result_t result_reg;
    trit_pkg::result_t result_next;

    logic [XW-1:0] mag_c [4][3];
    logic [XW-1:0] mag_d [4][3];
    logic on_line [4][3];
    logic [3:0] inside_next;
    logic [11:0] cross_next;
    logic signed [XW-1:0] uu;
    logic tok, uok;

    function automatic logic ratio_ok(input logic signed [XW-1:0] n,
                                      input logic signed [XW-1:0] d);
        logic r;
        if (d >= 0) r = (n >= 0) && (n < d);
        else r = (n <= 0) && (d < n);
        return r;
    endfunction

    always_comb
    begin
        cxs[0] = DW'(job.left);
        cys[0] = DW'(job.top);
        cxs[1] = DW'(job.right);
        cys[1] = DW'(job.top);
        cxs[2] = DW'(job.right);
        cys[2] = DW'(job.bottom);
        cxs[3] = DW'(job.left);
        cys[3] = DW'(job.bottom);
        for (int i = 0; i < 3; i++)
        begin
            ex[i] = DW'($signed(job.vx[(i + 1) % 3])) - DW'($signed(job.vx[i]));
            ey[i] = DW'($signed(job.vy[(i + 1) % 3])) - DW'($signed(job.vy[i]));
        end
        for (int k = 0; k < 4; k++)
        begin
            bx[k] = cxs[(k + 1) % 4] - cxs[k];
            by[k] = cys[(k + 1) % 4] - cys[k];
            for (int i = 0; i < 3; i++)
            begin
                px[k][i] = cxs[k] - DW'($signed(job.vx[i]));
                py[k][i] = cys[k] - DW'($signed(job.vy[i]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pc1_reg[k][i] <= ex[i] * py[k][i];
                pc2_reg[k][i] <= ey[i] * px[k][i];
                pd1_reg[k][i] <= ex[i] * by[k];
                pd2_reg[k][i] <= ey[i] * bx[k];
                pt1_reg[k][i] <= px[k][i] * by[k];
                pt2_reg[k][i] <= py[k][i] * bx[k];
                cc_reg[k][i] <= XW'(pc1_reg[k][i]) - XW'(pc2_reg[k][i]);
                dd_reg[k][i] <= XW'(pd1_reg[k][i]) - XW'(pd2_reg[k][i]);
                tt_reg[k][i] <= XW'(pt1_reg[k][i]) - XW'(pt2_reg[k][i]);
            end
        end
        s1_apart_reg <= job.apart;
        s2_apart_reg <= s1_apart_reg;
        s3_apart_reg <= s2_apart_reg;
        inside_reg <= inside_next;
        cross_reg <= cross_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        uu = '0;
        tok = 1'b0;
        uok = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_c[k][i] = cc_reg[k][i][XW-1] ? XW'(-cc_reg[k][i]) : XW'(cc_reg[k][i]);
                mag_d[k][i] = dd_reg[k][i][XW-1] ? XW'(-dd_reg[k][i]) : XW'(dd_reg[k][i]);
                on_line[k][i] = mag_c[k][i] < XW'(on_edge_limit);
                uu = -cc_reg[k][i];
                tok = ratio_ok(tt_reg[k][i], dd_reg[k][i]);
                uok = ratio_ok(uu, dd_reg[k][i]);
                cross_next[i * 4 + k] = (mag_d[k][i] > XW'(parallel_limit)) && tok && uok;
            end
            inside_next[k] = on_line[k][0] || on_line[k][1]
                || ((cc_reg[k][1][XW-1] == cc_reg[k][0][XW-1])
                    && (on_line[k][2] || (cc_reg[k][2][XW-1] == cc_reg[k][0][XW-1])));
        end
        if (s3_apart_reg) result_next.cause = trit_pkg::CAUSE_APART;
        else if (|inside_reg) result_next.cause = trit_pkg::CAUSE_CORNER;
        else if (|cross_reg) result_next.cause = trit_pkg::CAUSE_CROSS;
        else result_next.cause = trit_pkg::CAUSE_NONE;
        result_next.hit = !s3_apart_reg && ((|inside_reg) || (|cross_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg <= s3_valid_reg;
        end
    end

    assign done = done_reg;
    assign result = result_reg;
endmodule

[rtl/core/triangle_rect_intersection_test_unit.sv]
// Top level of the triangle and rectangle intersection test unit.
// Depends on trit_pkg, trit_front, trit_queue and trit_back.
//
// One triangle and rectangle pair is taken in every clock cycle in which start is high and
// busy is low, and its answer appears on result with done high after passing the front-end
// register, the queue and the back end's multiply, subtract, compare and combine stages.
// The back end drains one job per cycle and the receiver takes each result when it is shown,
// so the queue never fills and busy stays low in normal use.
// The limit registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while no pair is in flight, which the block itself does not enforce.
module triangle_rect_intersection_test_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  trit_pkg::pair_t                    pair,
    output logic                               done,
    output trit_pkg::result_t                  result,
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_index,
    input  logic [trit_pkg::LIMIT_BITS-1:0]    cfg_data
);
    logic [trit_pkg::LIMIT_BITS-1:0] parallel_limit_reg, on_edge_limit_reg;
    logic take, push, pop;
    trit_pkg::job_t front_job, back_job;
    trit_pkg::queue_stat_t qstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parallel_limit_reg <= trit_pkg::PARALLEL_LIMIT_RESET;
            on_edge_limit_reg <= trit_pkg::ON_EDGE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                trit_pkg::REG_PARALLEL_LIMIT: parallel_limit_reg <= cfg_data;
                trit_pkg::REG_ON_EDGE_LIMIT: on_edge_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = qstat.full;
    assign take = start && !busy;
    assign pop = !qstat.empty;

    trit_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .pair(pair),
        .push(push), .job(front_job)
    );

    trit_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .din(front_job),
        .pop(pop), .dout(back_job), .stat(qstat)
    );

    trit_back u_back (
        .clk(clk), .rst_n(rst_n), .pop(pop), .job(back_job),
        .parallel_limit(parallel_limit_reg), .on_edge_limit(on_edge_limit_reg),
        .done(done), .result(result)
    );

    a_hit_matches_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hit == ((result.cause == trit_pkg::CAUSE_CORNER)
                                 || (result.cause == trit_pkg::CAUSE_CROSS))))
        else $error("hit disagrees with cause");
    a_done_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(pop, 4))
        else $error("result without a dequeued job");
    a_push_follows_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> push)
        else $error("accepted pair not queued");
endmodule
